// File: rtl/lpfd_pkg.sv
// Package for the lidar point frame decoder.
// Holds frame constants, CORDIC arctangent table and shared types. No dependencies.
package lpfd_pkg;

  localparam int FRAME_BYTES = 47;
  localparam int POINTS = 12;
  localparam logic [7:0] HDR_FIRST = 8'h54;
  localparam logic [7:0] HDR_SECOND = 8'h2C;
  localparam int CORDIC_STEPS = 16;
  localparam int XY_LIMIT = 131056;

  // Width of the CORDIC datapath (x, y up to 8191*39797*~1.7 < 2^30).
  localparam int CW = 34;
  localparam int ZW = 27;

  function automatic logic [ZW-1:0] atan_entry(input logic [3:0] idx);
    logic [ZW-1:0] r;
    unique case (idx)
      4'd0: r = 27'd18432000;
      4'd1: r = 27'd10881045;
      4'd2: r = 27'd5749245;
      4'd3: r = 27'd2918407;
      4'd4: r = 27'd1464867;
      4'd5: r = 27'd733147;
      4'd6: r = 27'd366663;
      4'd7: r = 27'd183343;
      4'd8: r = 27'd91673;
      4'd9: r = 27'd45837;
      4'd10: r = 27'd22918;
      4'd11: r = 27'd11459;
      4'd12: r = 27'd5730;
      4'd13: r = 27'd2865;
      4'd14: r = 27'd1432;
      default: r = 27'd716;
    endcase
    return r;
  endfunction

  // Request from the sequencer to the rotation unit.
  typedef struct packed {
    logic start;
    logic [12:0] range_mm;
    logic [15:0] angle;
  } cordic_req_t;

  typedef struct packed {
    logic done;
    logic signed [17:0] x;
    logic signed [17:0] y;
  } cordic_rsp_t;

endpackage

// File: rtl/lidar_point_frame_decoder.sv
// Lidar point frame decoder top level: header hunt, frame store, point sequencer.
// Depends on lpfd_pkg and lpfd_cordic.
//
// Usage: rx_byte words enter on rx_valid/rx_ready, one serial byte each.
// A frame opens with 0x54 then 0x2C; a wrong second byte returns to hunting.
// 47 bytes are stored; on the last byte twelve points are produced on the
// point channel (out_valid/out_ready), point_number 0..11, last_point on 11.
// Header and body bytes are taken while rx_ready is high. After the last byte,
// the start and end angles are fetched from the store. Each point then goes
// through store reads and interpolation (two products, reciprocal divide by
// 11), a hand-off to and wait on the single CORDIC unit, and the output
// register; rx_ready is low meanwhile.
// The output register holds a point until taken; a stalled receiver stops
// the sequencer, and the frame store is not touched until all 12 are out.
// Reset returns the decoder to hunting; stored bytes are left undefined.
module lidar_point_frame_decoder
  import lpfd_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               rx_valid,
  output logic               rx_ready,
  input  logic [7:0]         rx_byte,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [3:0]         point_number,
  output logic [15:0]        angle_centideg,
  output logic [12:0]        distance_mm,
  output logic [7:0]         intensity,
  output logic signed [17:0] x_pos,
  output logic signed [17:0] y_pos,
  output logic               last_point
);

  typedef enum logic [3:0] {
    S_HUNT, S_BODY, S_SA0, S_SA1, S_EA0, S_EA1,
    S_RD0, S_RD1, S_RD2, S_MUL, S_DIV, S_ROT, S_OUT
  } st_t;
  st_t state;

  logic [7:0] mem [FRAME_BYTES];
  logic [5:0] pos;
  logic [5:0] raddr;
  logic [7:0] rdata;
  logic [3:0] pt;
  logic [15:0] s_ang, e_ang;
  logic [12:0] range_mm;
  logic [7:0] inten;
  logic [20:0] prod;
  logic [15:0] ang;
  logic [1:0] mstep;
  logic [40:0] recip;
  cordic_req_t req;
  cordic_rsp_t rsp;
  logic wr;

  assign rx_ready = (state == S_HUNT) || (state == S_BODY);
  assign wr = rx_valid && rx_ready;

  // Frame store: one write, one registered read
  always_ff @(posedge clk) begin
    if (wr && (pos != 6'd0 || rx_byte == HDR_FIRST)) mem[pos] <= rx_byte;
    rdata <= mem[raddr];
  end

  lpfd_cordic u_cordic (.clk(clk), .rst(rst), .req(req), .rsp(rsp));

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_HUNT;
      pos <= '0;
      out_valid <= 1'b0;
      req.start <= 1'b0;
    end else begin
      unique case (state)
        S_HUNT: begin
          if (rx_valid && rx_byte == HDR_FIRST) begin
            pos <= 6'd1;
            state <= S_BODY;
          end
        end
        S_BODY: begin
          if (rx_valid) begin
            if (pos == 6'd1 && rx_byte != HDR_SECOND) begin
              pos <= '0;
              state <= S_HUNT;
            end else if (pos == 6'(FRAME_BYTES - 1)) begin
              pos <= '0;
              raddr <= 6'd2;
              state <= S_SA0;
            end else begin
              pos <= pos + 6'd1;
            end
          end
        end
        S_SA0: begin raddr <= 6'd3; state <= S_SA1; end
        S_SA1: begin s_ang[7:0] <= rdata; raddr <= 6'd42; state <= S_EA0; end
        S_EA0: begin s_ang[15:8] <= rdata; raddr <= 6'd43; state <= S_EA1; end
        S_EA1: begin
          e_ang[7:0] <= rdata;
          pt <= '0;
          raddr <= 6'd4;
          state <= S_RD0;
        end
        S_RD0: begin
          if (pt == 4'd0) e_ang[15:8] <= rdata;
          raddr <= raddr + 6'd1;
          state <= S_RD1;
        end
        S_RD1: begin
          range_mm[7:0] <= rdata;
          raddr <= raddr + 6'd1;
          state <= S_RD2;
        end
        S_RD2: begin
          range_mm[12:8] <= rdata[4:0];
          raddr <= raddr + 6'd1;
          prod <= 21'(4'd11 - pt) * 21'(s_ang);
          mstep <= '0;
          state <= S_MUL;
        end
        // second product, then reciprocal multiply
        S_MUL: begin
          inten <= rdata;
          prod <= prod + 21'(pt) * 21'(e_ang);
          state <= S_DIV;
        end
        S_DIV: begin
          mstep <= mstep + 2'd1;
          if (mstep == 2'd0) begin
            recip <= 41'(prod) * 41'(20'd762601);   // ceil(2^23/11)
          end else begin
            ang <= 16'(recip >> 23);
            req.start <= 1'b1;
            req.range_mm <= range_mm;
            req.angle <= 16'(recip >> 23);
            state <= S_ROT;
          end
        end
        S_ROT: begin
          req.start <= 1'b0;
          if (rsp.done) begin
            point_number <= pt;
            angle_centideg <= ang;
            distance_mm <= range_mm;
            intensity <= inten;
            x_pos <= rsp.x;
            y_pos <= rsp.y;
            last_point <= (pt == 4'(POINTS - 1));
            out_valid <= 1'b1;
            state <= S_OUT;
          end
        end
        default: begin
          if (out_ready) begin
            out_valid <= 1'b0;
            if (pt == 4'(POINTS - 1)) begin
              state <= S_HUNT;
            end else begin
              pt <= pt + 4'd1;
              state <= S_RD0;
            end
          end
        end
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  a_no_rx_while_out: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !rx_ready) else $error("byte taken while point pending");
  a_pt_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> point_number < 4'd12) else $error("point index out of range");
  a_last: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (last_point == (point_number == 4'd11))) else $error("bad last flag");
`endif

endmodule

// File: rtl/lpfd_cordic.sv
// Iterative CORDIC rotation: one shift-add step per cycle, plus range reduction.
// Depends on lpfd_pkg.
module lpfd_cordic
  import lpfd_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  cordic_req_t req,
  output cordic_rsp_t rsp
);

  typedef enum logic [2:0] {S_IDLE, S_RED1, S_RED2, S_PRE, S_ROT, S_FIN} st_t;
  st_t state;

  logic signed [CW-1:0] x, y;
  logic signed [ZW:0] z;
  logic signed [17:0] a;      // reduced angle, centidegrees
  logic [16:0] amod;
  logic neg;
  logic [3:0] step;
  logic [12:0] range_mm;
  logic signed [CW-1:0] xs, ys;
  logic signed [17:0] xo, yo;

  assign xs = x >>> step;
  assign ys = y >>> step;

  // Rounding, sign fix and saturation of one coordinate
  function automatic logic signed [17:0] fin(input logic signed [CW-1:0] v,
                                             input logic n);
    logic signed [CW-1:0] t;
    logic signed [CW-1:0] r;
    t = n ? -v : v;
    r = (t + CW'(2048)) >>> 12;
    if (r > CW'(XY_LIMIT)) return 18'(XY_LIMIT);
    if (r < -CW'(XY_LIMIT)) return -18'(XY_LIMIT);
    return r[17:0];
  endfunction

  assign xo = fin(x, neg);
  assign yo = fin(y, neg);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      rsp.done <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          rsp.done <= 1'b0;
          if (req.start) begin
            range_mm <= req.range_mm;
            amod <= {1'b0, req.angle};
            state <= S_RED1;
          end
        end
        // angle mod 36000 (input < 65536, so one subtract)
        S_RED1: begin
          if (amod >= 17'd36000) amod <= amod - 17'd36000;
          state <= S_RED2;
        end
        // fold into [-9000, 9000], flipping the sign of the result outside it
        S_RED2: begin
          neg <= 1'b0;
          if (amod >= 17'd18000) begin
            if (amod < 17'd27000) begin
              a <= $signed({1'b0, amod}) - 18'sd18000;
              neg <= 1'b1;
            end else begin
              a <= $signed({1'b0, amod}) - 18'sd36000;
            end
          end else if (amod > 17'd9000) begin
            a <= $signed({1'b0, amod}) - 18'sd18000;
            neg <= 1'b1;
          end else begin
            a <= $signed({1'b0, amod});
          end
          state <= S_PRE;
        end
        S_PRE: begin
          x <= CW'(29'(range_mm) * 29'd39797);
          y <= '0;
          z <= (ZW+1)'(a) <<< 12;
          step <= '0;
          state <= S_ROT;
        end
        S_ROT: begin
          if (!z[ZW]) begin
            x <= x - ys;
            y <= y + xs;
            z <= z - $signed({1'b0, atan_entry(step)});
          end else begin
            x <= x + ys;
            y <= y - xs;
            z <= z + $signed({1'b0, atan_entry(step)});
          end
          step <= step + 4'd1;
          if (step == 4'(CORDIC_STEPS - 1)) state <= S_FIN;
        end
        default: begin
          rsp.x <= xo;
          rsp.y <= yo;
          rsp.done <= 1'b1;
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// File: tb/tb_lidar_point_frame_decoder.sv
// Testbench for lidar_point_frame_decoder: frame hunt, point decode and XY rotation.
// Depends on lpfd_pkg and the decoder RTL; self-checking against an in-bench predictor.
module tb_lidar_point_frame_decoder;
  import lpfd_pkg::*;

  typedef struct {
    logic [3:0]         num;
    logic [15:0]        ang;
    logic [12:0]        range_mm;
    logic [7:0]         inten;
    logic signed [17:0] xp;
    logic signed [17:0] yp;
    logic               last;
    logic               known;  // directed row with typed-in values
  } point_t;

  typedef struct {
    logic [7:0] b;
  } row_t;

  // body fill for queue_frame
  localparam int FILL_RANDOM = 0;
  localparam int FILL_MAX = 1;
  localparam int FILL_ZERO = 2;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic rx_valid = 1'b0;
  logic rx_ready;
  logic [7:0] rx_byte = 8'h00;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [3:0] point_number;
  logic [15:0] angle_centideg;
  logic [12:0] distance_mm;
  logic [7:0] intensity;
  logic signed [17:0] x_pos;
  logic signed [17:0] y_pos;
  logic last_point;

  lidar_point_frame_decoder DUT (
    .clk(clk), .rst(rst),
    .rx_valid(rx_valid), .rx_ready(rx_ready), .rx_byte(rx_byte),
    .out_valid(out_valid), .out_ready(out_ready),
    .point_number(point_number), .angle_centideg(angle_centideg),
    .distance_mm(distance_mm), .intensity(intensity),
    .x_pos(x_pos), .y_pos(y_pos), .last_point(last_point)
  );

  always #6 clk = ~clk;

  // predictor state
  int unsigned hunt_pos;
  logic [7:0]  frame_bytes [FRAME_BYTES];
  point_t      pending_points [$];
  point_t      known_points [$];
  logic [7:0]  word_queue [$];
  int          errors = 0;
  int          points_seen = 0;
  int          frames_sent = 0;
  longint      cycle_count = 0;
  bit          long_holdoff = 1'b0;

  localparam longint CYCLE_LIMIT = 2000000;

  localparam longint ATAN_T [16] = '{
    18432000, 10881045, 5749245, 2918407, 1464867, 733147, 366663, 183343,
    91673, 45837, 22918, 11459, 5730, 2865, 1432, 716};

  function automatic longint fshr(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint round_sat(longint v, bit neg);
    longint r;
    if (neg) v = -v;
    r = fshr(v + 2048, 12);
    if (r > XY_LIMIT) r = XY_LIMIT;
    if (r < -XY_LIMIT) r = -XY_LIMIT;
    return r;
  endfunction

  // fixed-point rotation of (d, 0) by the point angle
  task automatic rotate_point(input longint d, input longint ang,
                              output longint xo, output longint yo);
    longint a, x, y, z, nx, ny;
    bit neg;
    a = ang % 36000;
    neg = 1'b0;
    if (a >= 18000) a -= 36000;
    if (a > 9000) begin
      a -= 18000; neg = 1'b1;
    end else if (a < -9000) begin
      a += 18000; neg = 1'b1;
    end
    x = d * 39797;
    y = 0;
    z = a * 4096;
    for (int i = 0; i < 16; i++) begin
      if (z >= 0) begin
        nx = x - fshr(y, i); ny = y + fshr(x, i); z -= ATAN_T[i];
      end else begin
        nx = x + fshr(y, i); ny = y - fshr(x, i); z += ATAN_T[i];
      end
      x = nx; y = ny;
    end
    xo = round_sat(x, neg);
    yo = round_sat(y, neg);
  endtask

  // frame tracker: consume one accepted word, queue points on frame end
  task automatic track_word(input logic [7:0] b);
    longint s, e, ang, xv, yv, d;
    point_t p;
    int off;
    if (hunt_pos >= FRAME_BYTES) hunt_pos = 0;
    if (hunt_pos == 0 && b != HDR_FIRST) return;
    if (hunt_pos == 1 && b != HDR_SECOND) begin
      hunt_pos = 0;
      return;
    end
    frame_bytes[hunt_pos] = b;
    hunt_pos++;
    if (hunt_pos < FRAME_BYTES) return;
    hunt_pos = 0;
    s = longint'({frame_bytes[3], frame_bytes[2]});
    e = longint'({frame_bytes[43], frame_bytes[42]});
    for (int i = 0; i < POINTS; i++) begin
      off = 4 + 3 * i;
      d = longint'({frame_bytes[off + 1][4:0], frame_bytes[off]});
      ang = ((11 - i) * s + i * e) / 11;
      rotate_point(d, ang, xv, yv);
      p.num = i[3:0];
      p.ang = ang[15:0];
      p.range_mm = d[12:0];
      p.inten = frame_bytes[off + 2];
      p.xp = xv[17:0];
      p.yp = yv[17:0];
      p.last = (i == POINTS - 1);
      p.known = 1'b0;
      pending_points.push_back(p);
    end
  endtask

  // build one frame into the word queue
  task automatic queue_frame(input logic [15:0] s, input logic [15:0] e, input int mode);
    logic [7:0] f [FRAME_BYTES];
    for (int k = 0; k < FRAME_BYTES; k++) f[k] = 8'($urandom_range(0, 255));
    f[0] = HDR_FIRST; f[1] = HDR_SECOND;
    f[2] = s[7:0]; f[3] = s[15:8]; f[42] = e[7:0]; f[43] = e[15:8];
    for (int i = 0; i < POINTS; i++) begin
      if (mode == FILL_MAX) begin
        f[4 + 3 * i] = 8'hFF; f[5 + 3 * i] = 8'hFF; f[6 + 3 * i] = 8'hFF;
      end else if (mode == FILL_ZERO) begin
        f[4 + 3 * i] = 8'h00; f[5 + 3 * i] = 8'hE0; f[6 + 3 * i] = 8'h00;
      end
    end
    for (int k = 0; k < FRAME_BYTES; k++) word_queue.push_back(f[k]);
    frames_sent++;
  endtask

  // cycle counter and timeout
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // receiver: stall pattern plus long hold-offs while long_holdoff is set
  initial begin
    int n;
    @(negedge rst);
    forever begin
      @(posedge clk);
      if (long_holdoff) begin
        out_ready <= 1'b0;
        repeat (600) @(posedge clk);
        long_holdoff = 1'b0;
      end
      n = $urandom_range(0, 9);
      out_ready <= (n < 6) || (cycle_count % 4000 < 800);
    end
  end

  // output check
  always @(posedge clk) begin
    point_t p;
    if (!rst && out_valid && out_ready) begin
      points_seen++;
      if (pending_points.size() == 0) begin
        $error("point with no expectation: number %0d", point_number);
        errors++;
      end else begin
        p = pending_points.pop_front();
        if (point_number !== p.num) begin
          $error("point_number exp %0d got %0d", p.num, point_number); errors++;
        end
        if (angle_centideg !== p.ang) begin
          $error("angle_centideg exp %0d got %0d", p.ang, angle_centideg); errors++;
        end
        if (distance_mm !== p.range_mm) begin
          $error("distance_mm exp %0d got %0d", p.range_mm, distance_mm); errors++;
        end
        if (intensity !== p.inten) begin
          $error("intensity exp %0d got %0d", p.inten, intensity); errors++;
        end
        if (x_pos !== p.xp) begin
          $error("x_pos exp %0d got %0d", p.xp, x_pos); errors++;
        end
        if (y_pos !== p.yp) begin
          $error("y_pos exp %0d got %0d", p.yp, y_pos); errors++;
        end
        if (last_point !== p.last) begin
          $error("last_point exp %0d got %0d", p.last, last_point); errors++;
        end
      end
    end
  end

  // typed-in checks on the directed frames (extremes read at a glance)
  always @(posedge clk) begin
    point_t q;
    if (!rst && out_valid && out_ready && known_points.size() != 0) begin
      q = known_points.pop_front();
      if (q.known) begin
        if (distance_mm !== q.range_mm) begin
          $error("distance_mm exp %0d got %0d", q.range_mm, distance_mm); errors++;
        end
        if (intensity !== q.inten) begin
          $error("intensity exp %0d got %0d", q.inten, intensity); errors++;
        end
        if (angle_centideg !== q.ang) begin
          $error("angle_centideg exp %0d got %0d", q.ang, angle_centideg); errors++;
        end
      end
    end
  end

  // sender: drives one word on rx_byte and waits for rx_ready
  task automatic send_word(input logic [7:0] b);
    rx_valid <= 1'b1;
    rx_byte <= b;
    @(posedge clk);
    while (!rx_ready) @(posedge clk);
    track_word(b);
  endtask

  initial begin
    row_t directed [$];
    point_t kp;
    int burst, gap, nsent;
    logic [7:0] w;
    hunt_pos = 0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed table: junk, wrong second bytes, then headers
    directed = '{'{8'h00}, '{8'hFF}, '{8'h2C}, '{8'h54}, '{8'h54},
                 '{8'h54}, '{8'h00}, '{8'h54}, '{8'hFF}};
    foreach (directed[k]) word_queue.push_back(directed[k].b);
    // max distance/intensity, zero angle
    queue_frame(16'd0, 16'd0, FILL_MAX);
    for (int i = 0; i < POINTS; i++) begin
      kp.range_mm = 13'h1FFF; kp.inten = 8'hFF; kp.ang = 16'd0; kp.known = 1'b1;
      known_points.push_back(kp);
    end
    // zero distance (masked high bits), max angles
    queue_frame(16'hFFFF, 16'hFFFF, FILL_ZERO);
    for (int i = 0; i < POINTS; i++) begin
      kp.range_mm = 13'd0; kp.inten = 8'h00; kp.ang = 16'hFFFF; kp.known = 1'b1;
      known_points.push_back(kp);
    end
    queue_frame(16'd35000, 16'd100, FILL_RANDOM);   // falling interpolation
    queue_frame(16'd8000, 16'd28000, FILL_RANDOM);  // every quadrant
    nsent = 0;
    foreach (word_queue[k]) begin
      send_word(word_queue[k]);
      nsent++;
      rx_valid <= 1'b0;
      @(posedge clk);
    end
    word_queue.delete();
    // pause until all results are out
    while (pending_points.size() != 0) @(posedge clk);

    // random part: mostly frames, some noise
    while (nsent < 480) begin
      if ($urandom_range(0, 9) < 8)
        queue_frame(16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
                    FILL_RANDOM);
      else if ($urandom_range(0, 1))
        word_queue.push_back(8'($urandom_range(0, 255)));
      else begin
        word_queue.push_back(HDR_FIRST);
        word_queue.push_back(8'($urandom_range(0, 255)));
      end
      if (frames_sent == 5) long_holdoff = 1'b1;
      while (word_queue.size() != 0) begin
        burst = $urandom_range(1, 60);
        while (burst > 0 && word_queue.size() != 0) begin
          w = word_queue.pop_front();
          send_word(w);
          nsent++;
          burst--;
        end
        rx_valid <= 1'b0;
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
        repeat (gap) @(posedge clk);
        if (gap == 0) @(posedge clk);
      end
    end
    rx_valid <= 1'b0;

    while (pending_points.size() != 0) @(posedge clk);
    repeat (400) @(posedge clk);
    $display("Checked %0d points from %0d frames, with header noise and stalls.",
             points_seen, frames_sent);
    if (errors == 0 && pending_points.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// File: sim.f
rtl/lpfd_pkg.sv
rtl/lpfd_cordic.sv
rtl/lidar_point_frame_decoder.sv
tb/tb_lidar_point_frame_decoder.sv
